// ----- hw/rtl/sik_pkg.sv -----
// Shared constants, the arctangent table and its fixed-point conversion
// for the SCARA inverse kinematics core. No dependencies.
package sik_pkg;

  localparam int AngleFracBitsDef = 16;
  localparam int CordicSteps      = 32;
  localparam int SqrtSteps        = 31;
  localparam int SqrtW            = 62;
  localparam int VecW             = 55;
  localparam int PrepInW          = 33;
  localparam int NormMsb          = 50;
  localparam int CfgIdxW          = 2;
  localparam int CfgDataW         = 2;

  localparam logic [CfgIdxW-1:0] CfgElbowNeg = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHandOn   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgClawHole = 2'd2;

  localparam longint unsigned TableUnit = 64'd1000000000;

  // atan(2^-i) in units of 1e-9 of 0.1 degree.
  localparam longint unsigned AtanTab [CordicSteps] = '{
    64'd450000000000, 64'd265650511771, 64'd140362434679, 64'd71250163489,
    64'd35763343750, 64'd17899106082, 64'd8951737102, 64'd4476141709,
    64'd2238105004, 64'd1119056771, 64'd559528919, 64'd279764526,
    64'd139882271, 64'd69941137, 64'd34970569, 64'd17485284,
    64'd8742642, 64'd4371321, 64'd2185661, 64'd1092830,
    64'd546415, 64'd273208, 64'd136604, 64'd68302,
    64'd34151, 64'd17075, 64'd8538, 64'd4269,
    64'd2134, 64'd1067, 64'd534, 64'd267
  };

  // Rounds one table entry to frac fraction bits; used at elaboration only.
  function automatic longint unsigned sik_atan_entry(int step, int frac);
    longint unsigned q;
    longint unsigned r;
    q = AtanTab[step] / TableUnit;
    r = AtanTab[step] % TableUnit;
    return (q << frac) + (((r << frac) + TableUnit / 2) / TableUnit);
  endfunction

endpackage

// ----- hw/rtl/sik_sqrt_cell.sv -----
// One digit step of the pipelined integer square root.
// Depends on sik_pkg.
module sik_sqrt_cell import sik_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic             clk_i,
  input  logic [SqrtW-1:0] rem_i,
  input  logic [SqrtW-1:0] root_i,
  output logic [SqrtW-1:0] rem_o,
  output logic [SqrtW-1:0] root_o
);

  localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << (SqrtW - 2 - 2 * STEP);

  logic [SqrtW:0]   trial;
  logic [SqrtW-1:0] rem_d, root_d, rem_q, root_q;

  always_comb begin
    trial = {1'b0, root_i} + {1'b0, Bit};
    if ({1'b0, rem_i} >= trial) begin
      rem_d  = rem_i - trial[SqrtW-1:0];
      root_d = (root_i >> 1) + Bit;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/sik_cordic_prep.sv -----
// Quadrant fold and normalizing shift ahead of a vectoring CORDIC chain.
// Two register stages. Depends on sik_pkg.
module sik_cordic_prep import sik_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic                              clk_i,
  input  logic signed [PrepInW-1:0]         x_i,
  input  logic signed [PrepInW-1:0]         y_i,
  output logic signed [VecW-1:0]            x_o,
  output logic signed [VecW-1:0]            y_o,
  output logic signed [ANGLE_FRAC_BITS+12:0] z_o
);

  localparam int ZW = ANGLE_FRAC_BITS + 13;
  localparam int FW = PrepInW + 1;
  localparam logic signed [ZW-1:0] HalfTurn = ZW'(1800) <<< ANGLE_FRAC_BITS;

  logic signed [FW-1:0] fx_d, fy_d, fx_q, fy_q;
  logic signed [ZW-1:0] z1_d, z1_q, z2_q;
  logic [FW-1:0]        ymag, mag;
  logic [5:0]           msb_d, msb_q, shamt;
  logic signed [VecW-1:0] x2_q, y2_q;

  always_comb begin
    if (x_i < 0) begin
      fx_d = -FW'(x_i);
      fy_d = -FW'(y_i);
      z1_d = (y_i >= 0) ? HalfTurn : -HalfTurn;
    end else begin
      fx_d = FW'(x_i);
      fy_d = FW'(y_i);
      z1_d = '0;
    end
    ymag = fy_d[FW-1] ? FW'(-fy_d) : FW'(fy_d);
    mag  = (FW'(fx_d) > ymag) ? FW'(fx_d) : ymag;
    msb_d = '0;
    for (int i = 0; i < FW; i++) begin
      if (mag[i]) msb_d = 6'(i);
    end
  end

  assign shamt = 6'(NormMsb) - msb_q;

  always_ff @(posedge clk_i) begin
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    z1_q  <= z1_d;
    msb_q <= msb_d;
    x2_q  <= VecW'(fx_q) <<< shamt;
    y2_q  <= VecW'(fy_q) <<< shamt;
    z2_q  <= z1_q;
  end

  assign x_o = x2_q;
  assign y_o = y2_q;
  assign z_o = z2_q;

endmodule

// ----- hw/rtl/sik_cordic_cell.sv -----
// One rotation step of the vectoring CORDIC, registered.
// Depends on sik_pkg for the arctangent table.
module sik_cordic_cell import sik_pkg::*; #(
  parameter int STEP            = 0,
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic                               clk_i,
  input  logic signed [VecW-1:0]             x_i,
  input  logic signed [VecW-1:0]             y_i,
  input  logic signed [ANGLE_FRAC_BITS+12:0] z_i,
  output logic signed [VecW-1:0]             x_o,
  output logic signed [VecW-1:0]             y_o,
  output logic signed [ANGLE_FRAC_BITS+12:0] z_o
);

  localparam int ZW = ANGLE_FRAC_BITS + 13;
  localparam logic signed [ZW-1:0] Tab = ZW'(sik_atan_entry(STEP, ANGLE_FRAC_BITS));

  logic signed [VecW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0]   z_d, z_q;

  always_comb begin
    dx = x_i >>> STEP;
    dy = y_i >>> STEP;
    if (!y_i[VecW-1]) begin
      x_d = x_i + dy;
      y_d = y_i - dx;
      z_d = z_i + Tab;
    end else begin
      x_d = x_i - dy;
      y_d = y_i + dx;
      z_d = z_i - Tab;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

// ----- hw/rtl/scara_inverse_kinematics_core.sv -----
// Top level of the SCARA inverse kinematics core: frame shift, radius,
// square root chain, two CORDIC chains and joint assembly. Uses sik_pkg.
//
//  channel | signals                                  | transaction when
//  --------+------------------------------------------+-------------------
//  target  | start, busy, x_pos_i .. grip_width_i     | start && !busy
//  joints  | done_o, base_joint_o .. out_of_reach_o   | done_o (one cycle)
//  config  | cfg_we_i, cfg_idx_i, cfg_wdata_i         | cfg_we_i
//
// A new target is taken in every clock cycle; busy is always low. Each
// target passes the input stages, the 31 cell square root chain, the
// two-stage prep, the 32 cell CORDIC chains and the final stages before
// its joint set comes out. Reset clears the valid pipe and sets the
// registers to elbow counterclockwise, hand axes on and claw hole 1. The
// receiver cannot hold results off, so nothing in the pipe ever stalls.
module scara_inverse_kinematics_core import sik_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic signed [12:0]  x_pos_i,
  input  logic signed [12:0]  y_pos_i,
  input  logic signed [10:0]  z_height_i,
  input  logic signed [12:0]  yaw_angle_i,
  input  logic [8:0]          grip_width_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic signed [11:0]  base_joint_o,
  output logic signed [11:0]  elbow_joint_o,
  output logic signed [12:0]  lift_joint_o,
  output logic signed [13:0]  wrist_joint_o,
  output logic signed [9:0]   grip_joint_o,
  output logic                out_of_reach_o
);

  localparam int ZW       = ANGLE_FRAC_BITS + 13;
  localparam int SW       = ZW + 2;
  localparam int PrepLat  = 2;
  localparam int SideLat  = SqrtSteps + PrepLat + CordicSteps;
  localparam int Latency  = SideLat + 6;
  // Reciprocals for the two constant divisions; exact over the value ranges.
  localparam int LiftSh   = 36;
  localparam longint unsigned LiftK = ((64'd1 << LiftSh) + 64'd1749) / 64'd1750;
  localparam int GripSh   = 32;
  localparam longint unsigned GripK = ((64'd1 << GripSh) + 64'd999) / 64'd1000;

  // Data that rides alongside the square root and CORDIC chains.
  typedef struct packed {
    logic               reach;
    logic               rzero;
    logic signed [12:0] yaw;
    logic signed [12:0] lift;
    logic signed [9:0]  grip;
    logic signed [13:0] tx;
    logic signed [13:0] ty;
    logic signed [31:0] cosp;
  } side_t;

  // Configuration registers.
  logic       elbow_neg_q, hand_on_q;
  logic [1:0] claw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elbow_neg_q <= 1'b1;
      hand_on_q   <= 1'b1;
      claw_q      <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgElbowNeg: elbow_neg_q <= cfg_wdata_i[0];
        CfgHandOn:   hand_on_q   <= cfg_wdata_i[0];
        CfgClawHole: claw_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline takes one target per cycle unconditionally.
  assign busy = 1'b0;

  // Valid bits for every pipeline level.
  logic               v1_q, v2_q, v3_q, f1_v_q, f2_v_q;
  logic [SideLat:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vld_q  <= '0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      v1_q   <= start && !busy;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vld_q  <= {vld_q[SideLat-1:0], v3_q};
      f1_v_q <= vld_q[SideLat];
      f2_v_q <= f1_v_q;
    end
  end

  // Stage 1: move the target into the arm base frame.
  logic signed [13:0] s1_tx_q, s1_ty_q;
  logic signed [10:0] s1_z_q;
  logic signed [12:0] s1_yaw_q;
  logic [8:0]         s1_w_q;

  always_ff @(posedge clk_i) begin
    s1_tx_q  <= 14'sd620 - {x_pos_i[12], x_pos_i};
    s1_ty_q  <= -{y_pos_i[12], y_pos_i};
    s1_z_q   <= z_height_i;
    s1_yaw_q <= yaw_angle_i;
    s1_w_q   <= grip_width_i;
  end

  // Stage 2: squares, and the scaled lift and grip magnitudes.
  logic signed [27:0] txx_w, tyy_w;
  logic [10:0]        zmag;
  logic signed [9:0]  gdiff;
  logic [8:0]         gmag, claw_off;
  logic [25:0]        s2_txx_q, s2_tyy_q;
  logic [23:0]        s2_lm_q;
  logic [20:0]        s2_gm_q;
  logic               s2_lneg_q, s2_gneg_q;
  logic signed [13:0] s2_tx_q, s2_ty_q;
  logic signed [12:0] s2_yaw_q;

  always_comb begin
    txx_w = s1_tx_q * s1_tx_q;
    tyy_w = s1_ty_q * s1_ty_q;
    zmag  = s1_z_q[10] ? 11'(-s1_z_q) : 11'(s1_z_q);
    case (claw_q)
      2'd0:    claw_off = 9'd100;
      2'd1:    claw_off = 9'd200;
      2'd2:    claw_off = 9'd300;
      default: claw_off = 9'd400;
    endcase
    // The claw motor turns opposite to the opening, hence offset minus width.
    gdiff = $signed({1'b0, claw_off}) - $signed({1'b0, s1_w_q});
    gmag  = gdiff[9] ? 9'(-gdiff) : 9'(gdiff);
  end

  always_ff @(posedge clk_i) begin
    s2_txx_q  <= txx_w[25:0];
    s2_tyy_q  <= tyy_w[25:0];
    s2_lm_q   <= 24'(zmag * 13'd7427);
    s2_lneg_q <= s1_z_q[10];
    s2_gm_q   <= 21'(gmag * 12'd3183);
    s2_gneg_q <= gdiff[9];
    s2_tx_q   <= s1_tx_q;
    s2_ty_q   <= s1_ty_q;
    s2_yaw_q  <= s1_yaw_q;
  end

  // Stage 3: squared radius and quotients by reciprocal multiply.
  logic [26:0]        r2_sum;
  logic [49:0]        lq_w;
  logic [44:0]        gq_w;
  logic [25:0]        s3_r2_q;
  logic [12:0]        s3_lq_q;
  logic [10:0]        s3_gq_q;
  logic               s3_lneg_q, s3_gneg_q;
  logic signed [13:0] s3_tx_q, s3_ty_q;
  logic signed [12:0] s3_yaw_q;

  always_comb begin
    r2_sum = {1'b0, s2_txx_q} + {1'b0, s2_tyy_q};
    lq_w   = 50'(s2_lm_q * 26'(LiftK)) >> LiftSh;
    gq_w   = 45'(s2_gm_q * 24'(GripK)) >> GripSh;
  end

  always_ff @(posedge clk_i) begin
    s3_r2_q   <= r2_sum[25:0];
    s3_lq_q   <= lq_w[12:0];
    s3_gq_q   <= gq_w[10:0];
    s3_lneg_q <= s2_lneg_q;
    s3_gneg_q <= s2_gneg_q;
    s3_tx_q   <= s2_tx_q;
    s3_ty_q   <= s2_ty_q;
    s3_yaw_q  <= s2_yaw_q;
  end

  // Stage 4: reach test, the radicand of the bend sine, the bend cosine,
  // and the clamped lift and grip values.
  logic               reach_w;
  logic [21:0]        rr, rcomp;
  logic [43:0]        prod_w;
  logic signed [32:0] cdiff;
  logic [12:0]        lclamp;
  logic [9:0]         gclamp;
  side_t              side_d;
  side_t              side_q [SideLat+1];
  logic [SqrtW-1:0]   rem_c  [SqrtSteps+1];
  logic [SqrtW-1:0]   root_c [SqrtSteps+1];
  logic [41:0]        s4_prod_q;

  always_comb begin
    reach_w = s3_r2_q >= 26'd2560000;
    rr      = s3_r2_q[21:0];
    rcomp   = 22'd2560000 - rr;
    prod_w  = reach_w ? '0 : rr * rcomp;
    cdiff   = $signed({7'b0, s3_r2_q}) - 33'sd1280000;
    lclamp  = (s3_lq_q > 13'd2972) ? 13'd2972 : s3_lq_q;
    gclamp  = (s3_gq_q > 11'd350) ? 10'd350 : s3_gq_q[9:0];
    side_d.reach = reach_w;
    side_d.rzero = s3_r2_q == '0;
    side_d.yaw   = s3_yaw_q;
    side_d.lift  = s3_lneg_q ? -$signed(lclamp) : $signed(lclamp);
    side_d.grip  = s3_gneg_q ? -$signed(gclamp) : $signed(gclamp);
    side_d.tx    = s3_tx_q;
    side_d.ty    = s3_ty_q;
    // Only meaningful inside the reach, where the difference fits 22 bits.
    side_d.cosp  = {cdiff[21:0], 10'b0};
  end

  always_ff @(posedge clk_i) begin
    s4_prod_q <= prod_w[41:0];
    side_q[0] <= side_d;
    for (int i = 1; i <= SideLat; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Square root chain: sqrt(prod * 2^20) gives the scaled bend sine.
  assign rem_c[0]  = {s4_prod_q, 20'b0};
  assign root_c[0] = '0;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    sik_sqrt_cell #(.STEP(k)) u_cell (
      .clk_i  (clk_i),
      .rem_i  (rem_c[k]),
      .root_i (root_c[k]),
      .rem_o  (rem_c[k+1]),
      .root_o (root_c[k+1])
    );
  end

  // Two CORDIC chains: bend angle (chain a) and target bearing (chain b).
  logic signed [VecW-1:0] ax [CordicSteps+1];
  logic signed [VecW-1:0] ay [CordicSteps+1];
  logic signed [ZW-1:0]   az [CordicSteps+1];
  logic signed [VecW-1:0] bx [CordicSteps+1];
  logic signed [VecW-1:0] by [CordicSteps+1];
  logic signed [ZW-1:0]   bz [CordicSteps+1];

  sik_cordic_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_a (
    .clk_i (clk_i),
    .x_i   ({side_q[SqrtSteps].cosp[31], side_q[SqrtSteps].cosp}),
    .y_i   ({2'b0, root_c[SqrtSteps][30:0]}),
    .x_o   (ax[0]),
    .y_o   (ay[0]),
    .z_o   (az[0])
  );

  sik_cordic_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep_b (
    .clk_i (clk_i),
    .x_i   (PrepInW'(side_q[SqrtSteps].tx)),
    .y_i   (PrepInW'(side_q[SqrtSteps].ty)),
    .x_o   (bx[0]),
    .y_o   (by[0]),
    .z_o   (bz[0])
  );

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    sik_cordic_cell #(.STEP(k), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cell_a (
      .clk_i (clk_i),
      .x_i   (ax[k]),
      .y_i   (ay[k]),
      .z_i   (az[k]),
      .x_o   (ax[k+1]),
      .y_o   (ay[k+1]),
      .z_o   (az[k+1])
    );
    sik_cordic_cell #(.STEP(k), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cell_b (
      .clk_i (clk_i),
      .x_i   (bx[k]),
      .y_i   (by[k]),
      .z_i   (bz[k]),
      .x_o   (bx[k+1]),
      .y_o   (by[k+1]),
      .z_o   (bz[k+1])
    );
  end

  // Drops k fraction bits, rounding toward zero.
  function automatic logic signed [13:0] trunc_frac(logic signed [SW-1:0] v, int k);
    logic [SW-1:0] mag;
    logic [SW-1:0] sh;
    mag = v[SW-1] ? SW'(-v) : SW'(v);
    sh  = mag >> k;
    return v[SW-1] ? -$signed(sh[13:0]) : $signed(sh[13:0]);
  endfunction

  function automatic logic signed [11:0] clamp_arm(logic signed [13:0] v);
    if (v > 14'sd1350) return 12'sd1350;
    if (v < -14'sd1350) return -12'sd1350;
    return v[11:0];
  endfunction

  // Final stage 1: base and elbow. With the bend d and bearing a, the base
  // is a + s*d/2 and the elbow -s*d; s = -1 for a counterclockwise elbow.
  side_t              fs;
  logic signed [SW-1:0] a_ext, d_ext, sum2, elb_src;
  logic signed [13:0] base_raw, elbow_raw;
  logic signed [11:0] f1_base_q, f1_elbow_q;
  logic               f1_reach_q;
  logic signed [12:0] f1_yaw_q, f1_lift_q;
  logic signed [9:0]  f1_grip_q;

  always_comb begin
    fs      = side_q[SideLat];
    a_ext   = SW'(bz[CordicSteps]);
    d_ext   = SW'(az[CordicSteps]);
    sum2    = (a_ext <<< 1) + (elbow_neg_q ? -d_ext : d_ext);
    elb_src = elbow_neg_q ? d_ext : -d_ext;
    if (fs.reach) begin
      base_raw  = trunc_frac(a_ext, ANGLE_FRAC_BITS);
      elbow_raw = '0;
    end else begin
      // Target on the base axis: bearing is undefined, base is held at zero.
      base_raw  = fs.rzero ? '0 : trunc_frac(sum2, ANGLE_FRAC_BITS + 1);
      elbow_raw = trunc_frac(elb_src, ANGLE_FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    f1_base_q  <= clamp_arm(base_raw);
    f1_elbow_q <= clamp_arm(elbow_raw);
    f1_reach_q <= fs.reach;
    f1_yaw_q   <= fs.yaw;
    f1_lift_q  <= fs.lift;
    f1_grip_q  <= fs.grip;
  end

  // Final stage 2: wrist from the clamped joints, hand axis gating.
  logic signed [13:0] wrist_w;
  logic signed [11:0] f2_base_q, f2_elbow_q;
  logic signed [12:0] f2_lift_q;
  logic signed [13:0] f2_wrist_q;
  logic signed [9:0]  f2_grip_q;
  logic               f2_reach_q;

  assign wrist_w = 14'(f1_yaw_q) - 14'(f1_base_q) - 14'(f1_elbow_q);

  always_ff @(posedge clk_i) begin
    f2_base_q  <= f1_base_q;
    f2_elbow_q <= f1_elbow_q;
    f2_lift_q  <= f1_lift_q;
    f2_wrist_q <= hand_on_q ? wrist_w : '0;
    f2_grip_q  <= hand_on_q ? f1_grip_q : '0;
    f2_reach_q <= f1_reach_q;
  end

  assign done_o         = f2_v_q;
  assign base_joint_o   = f2_base_q;
  assign elbow_joint_o  = f2_elbow_q;
  assign lift_joint_o   = f2_lift_q;
  assign wrist_joint_o  = f2_wrist_q;
  assign grip_joint_o   = f2_grip_q;
  assign out_of_reach_o = f2_reach_q;

  // Every taken target comes out a fixed number of cycles later.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency done_o)
    else $error("result missing at fixed latency");

  a_reach_elbow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_reach_o |-> elbow_joint_o == '0)
    else $error("elbow not zero out of reach");

  a_arm_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> base_joint_o <= 12'sd1350 && base_joint_o >= -12'sd1350 &&
               elbow_joint_o <= 12'sd1350 && elbow_joint_o >= -12'sd1350)
    else $error("arm joint beyond clamp");

  a_hand_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(!hand_on_q) |-> wrist_joint_o == '0 && grip_joint_o == '0)
    else $error("hand joints not zero with hand axes off");

endmodule
